### rtl/core/dda_pkg.sv
package dda_pkg;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_NEXT  = 1'b1
    } t_cmd;

endpackage

### rtl/core/dda_line_rasterizer_core.sv
// Fixed-point DDA line rasterizer. A start beat (s_axis_tuser = CMD_START) loads
// two endpoints. The core then runs one restoring divider, one quotient bit per
// cycle, first for the x increment and then for the y increment. During that
// time s_axis_tready is low. A zero-length line needs no division, and the core
// is ready again in the next cycle. After setup, each next beat (CMD_NEXT) sends
// out one pixel in the next cycle through a registered output stage. While the
// sink keeps taking beats, pixels go out at one per cycle. A line produces
// max(|dx|,|dy|) pixels and does not draw the end point. m_axis_tlast marks the
// final pixel. A start beat produces no output. A next beat while no line is
// active is accepted and dropped.
module dda_line_rasterizer_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // start_x, start_y, end_x, end_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // cmd
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // pixel_x, pixel_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                    m_axis_tlast
);

    localparam int AW     = COORD_BITS + FRAC_BITS + 1;
    localparam int DW     = COORD_BITS + 1;
    localparam int QW     = FRAC_BITS + 2;
    localparam int OUT_W  = ((2*COORD_BITS+7)/8)*8;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(FRAC_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_acc_x;
    logic [AW-1:0]           r_acc_y;
    logic [QW-1:0]           r_inc_x;
    logic [QW-1:0]           r_inc_y;
    logic [COORD_BITS-1:0]   r_remaining;
    logic [COORD_BITS-1:0]   r_steps;
    logic [DW-1:0]           r_rem;
    logic [DW-1:0]           r_ady;
    logic                    r_neg_x;
    logic                    r_neg_y;
    logic [FRAC_BITS:0]      r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_m_valid;
    logic [COORD_BITS-1:0]   r_px;
    logic [COORD_BITS-1:0]   r_py;
    logic                    r_last;

    logic                    w_s_acc;
    logic                    w_emit;
    logic [COORD_BITS-1:0]   w_sx;
    logic [COORD_BITS-1:0]   w_sy;
    logic [COORD_BITS-1:0]   w_ex;
    logic [COORD_BITS-1:0]   w_ey;
    logic [DW-1:0]           w_dx;
    logic [DW-1:0]           w_dy;
    logic [DW-1:0]           w_adx;
    logic [DW-1:0]           w_ady;
    logic [DW-1:0]           w_steps;
    logic                    w_ge;
    logic [DW-1:0]           w_sub;
    logic [DW-1:0]           n_rem;
    logic [FRAC_BITS:0]      n_quo;
    logic [QW-1:0]           w_inc;
    logic                    w_neg;
    logic [DW-1:0]           w_ix;
    logic [DW-1:0]           w_iy;
    logic [COORD_BITS-1:0]   n_px;
    logic [COORD_BITS-1:0]   n_py;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_emit        = w_s_acc && (s_axis_tuser == dda_pkg::CMD_NEXT)
                         && (r_remaining != '0);

    assign w_sx = s_axis_tdata[COORD_BITS-1:0];
    assign w_sy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_ex = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_ey = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign w_dx    = {w_ex[COORD_BITS-1], w_ex} - {w_sx[COORD_BITS-1], w_sx};
    assign w_dy    = {w_ey[COORD_BITS-1], w_ey} - {w_sy[COORD_BITS-1], w_sy};
    assign w_adx   = w_dx[DW-1] ? -w_dx : w_dx;
    assign w_ady   = w_dy[DW-1] ? -w_dy : w_dy;
    assign w_steps = (w_adx >= w_ady) ? w_adx : w_ady;

    // shared restoring divider step
    assign w_ge  = r_rem >= {1'b0, r_steps};
    assign w_sub = w_ge ? r_rem - {1'b0, r_steps} : r_rem;
    assign n_rem = {w_sub[DW-2:0], 1'b0};
    assign n_quo = {r_quo[FRAC_BITS-1:0], w_ge};
    assign w_neg = (r_state == S_DIVX) ? r_neg_x : r_neg_y;
    assign w_inc = w_neg ? -{1'b0, n_quo} : {1'b0, n_quo};

    // truncate toward zero
    assign w_ix = r_acc_x[AW-1:FRAC_BITS]
                + DW'(r_acc_x[AW-1] && (|r_acc_x[FRAC_BITS-1:0]));
    assign w_iy = r_acc_y[AW-1:FRAC_BITS]
                + DW'(r_acc_y[AW-1] && (|r_acc_y[FRAC_BITS-1:0]));
    assign n_px = w_ix[COORD_BITS-1:0];
    assign n_py = w_iy[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_remaining <= '0;
            r_m_valid   <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_inc_x     <= '0;
            r_inc_y     <= '0;
            r_cnt       <= '0;
        end else begin
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc && (s_axis_tuser == dda_pkg::CMD_START)) begin
                        r_acc_x     <= {w_sx[COORD_BITS-1], w_sx, {FRAC_BITS{1'b0}}};
                        r_acc_y     <= {w_sy[COORD_BITS-1], w_sy, {FRAC_BITS{1'b0}}};
                        r_remaining <= w_steps[COORD_BITS-1:0];
                        r_steps     <= w_steps[COORD_BITS-1:0];
                        r_rem       <= w_adx;
                        r_ady       <= w_ady;
                        r_neg_x     <= w_dx[DW-1];
                        r_neg_y     <= w_dy[DW-1];
                        r_quo       <= '0;
                        r_cnt       <= CNT_TOP;
                        if (w_steps != '0) begin
                            r_state <= S_DIVX;
                        end
                    end else if (w_emit) begin
                        r_px        <= n_px;
                        r_py        <= n_py;
                        r_last      <= (r_remaining == COORD_BITS'(1));
                        r_acc_x     <= r_acc_x + {{(AW-QW){r_inc_x[QW-1]}}, r_inc_x};
                        r_acc_y     <= r_acc_y + {{(AW-QW){r_inc_y[QW-1]}}, r_inc_y};
                        r_remaining <= r_remaining - COORD_BITS'(1);
                    end
                end
                S_DIVX: begin
                    if (r_cnt == '0) begin
                        r_inc_x <= w_inc;
                        r_rem   <= r_ady;
                        r_quo   <= '0;
                        r_cnt   <= CNT_TOP;
                        r_state <= S_DIVY;
                    end else begin
                        r_quo <= n_quo;
                        r_cnt <= r_cnt - CNT_W'(1);
                        r_rem <= n_rem;
                    end
                end
                S_DIVY: begin
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNT_W'(1);
                    r_rem <= n_rem;
                    if (r_cnt == '0) begin
                        r_inc_y <= w_inc;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_py, r_px});
    assign m_axis_tlast  = r_last;

endmodule

### rtl/core/dda_checker.sv
module dda_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input logic                                s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input logic                                m_axis_tlast
);

    logic w_s_acc;
    logic w_start;
    logic w_next;
    logic w_stall;

    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_start = w_s_acc && (s_axis_tuser == dda_pkg::CMD_START);
    assign w_next  = w_s_acc && (s_axis_tuser == dda_pkg::CMD_NEXT);
    assign w_stall = m_axis_tvalid && !m_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_setup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start && (s_axis_tdata[COORD_BITS-1:0] != s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])
        |=> !s_axis_tready)
        else $error("input ready during line setup");

    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !m_axis_tvalid)
        else $error("start beat produced a pixel");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(w_stall) |-> $past(w_next))
        else $error("pixel without a next beat");

endmodule

bind dda_line_rasterizer_core dda_checker #(
    .COORD_BITS(COORD_BITS)
) u_dda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
